/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/trle_pkg.sv */
// ---------------------------------------------------------------------------
// trle_pkg
// Types and constants shared by the text run-length encoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trle_pkg;

    // Encoding constants
    localparam logic [3:0] CHUNK_MAX  = 4'd9;   // longest run sent as one chunk
    localparam logic [3:0] RAW_MAX    = 4'd2;   // longest run sent as raw bytes
    localparam logic [7:0] DIGIT_BASE = 8'h30;  // ASCII '0'
    localparam logic [7:0] AT_SIGN    = 8'h40;  // ASCII '@'

    // Command queue geometry (depth is a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_of_item;
        logic       line_done;
    } t_out;

    // How one run segment is emitted
    typedef enum logic [1:0] {
        SEG_NONE,
        SEG_RAW,
        SEG_CODED
    } t_seg_kind;

    // One segment: raw repeat (num = 1..2) or digit/'@'/symbol (num = count)
    typedef struct packed {
        t_seg_kind  kind;
        logic [3:0] num;
        logic [7:0] sym;
    } t_seg;

    // Work for one input item: flush/chunk segment, then line-end flush
    typedef struct packed {
        t_seg seg0;
        t_seg seg1;
        logic line_end;
    } t_cmd;

endpackage

/* rtl/text_run_length_encoder.sv */
// ---------------------------------------------------------------------------
// text_run_length_encoder: one byte of a line per beat in, encoded bytes out.
// Commands wait in a 4-deep queue, which 2-4 byte items back up; output is registered.
// Throughput: 1 beat/cycle in while not full, 1 byte/cycle out while pop is held.
// Reset (sync, active low) clears run state, command queue and output valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_run_length_encoder import trle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic accept;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_out;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Run tracking and classification
    trle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // Command queue
    trle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    // Byte sequencing
    trle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    // Checks
    `ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, q_push, !q_full)
    `ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, !empty && o_result.line_done, o_result.last_of_item)
    `ASSERT_NEXT(a_out_refill, i_clk, i_rst_n, empty && !q_empty, !empty)
    `ASSERT_IMPLY(a_pop_has_cmd, i_clk, i_rst_n, q_pop, !q_empty)

endmodule

/* rtl/trle_front.sv */
// ---------------------------------------------------------------------------
// trle_front
// Tracks the open run and turns each input beat into an emit command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trle_front import trle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    output logic o_push,
    output t_cmd o_cmd
);

    // Run state
    logic [7:0] r_run_byte,  n_run_byte;
    logic [3:0] r_run_count, n_run_count;
    logic       r_run_split, n_run_split;

    logic       run_open;
    logic       same_byte;
    logic       chunk;
    logic [3:0] cnt_inc;
    logic [3:0] step_count;
    logic       step_split;
    t_seg       seg0;
    t_seg       seg1;

    // Classify how a run is flushed
    function automatic t_seg seg_flush(input logic [3:0] cnt, input logic split,
                                       input logic [7:0] sym);
        t_seg s;
        s.num = cnt;
        s.sym = sym;
        if (split) begin
            s.kind = (cnt != 4'd0) ? SEG_CODED : SEG_NONE;
        end else if (cnt > RAW_MAX) begin
            s.kind = SEG_CODED;
        end else if (cnt != 4'd0) begin
            s.kind = SEG_RAW;
        end else begin
            s.kind = SEG_NONE;
        end
        return s;
    endfunction

    // Extend or restart the run, emit a chunk on the ninth byte
    always_comb begin
        run_open  = (r_run_count != 4'd0) || r_run_split;
        same_byte = run_open && (i_item.data_byte == r_run_byte);
        cnt_inc   = r_run_count + 4'd1;
        chunk     = same_byte && (cnt_inc == CHUNK_MAX);

        if (same_byte) begin
            step_count = chunk ? 4'd0 : cnt_inc;
            step_split = r_run_split | chunk;
        end else begin
            step_count = 4'd1;
            step_split = 1'b0;
        end

        if (chunk) begin
            seg0.kind = SEG_CODED;
            seg0.num  = CHUNK_MAX;
            seg0.sym  = i_item.data_byte;
        end else if (run_open && !same_byte) begin
            seg0 = seg_flush(r_run_count, r_run_split, r_run_byte);
        end else begin
            seg0.kind = SEG_NONE;
            seg0.num  = 4'd0;
            seg0.sym  = 8'd0;
        end

        if (i_item.line_end) begin
            seg1 = seg_flush(step_count, step_split, i_item.data_byte);
        end else begin
            seg1.kind = SEG_NONE;
            seg1.num  = 4'd0;
            seg1.sym  = 8'd0;
        end

        // Line end returns the run to its reset state
        n_run_byte  = i_item.line_end ? 8'd0 : i_item.data_byte;
        n_run_count = i_item.line_end ? 4'd0 : step_count;
        n_run_split = i_item.line_end ? 1'b0 : step_split;
    end

    // Command out; items with nothing to emit are not queued
    assign o_cmd.seg0     = seg0;
    assign o_cmd.seg1     = seg1;
    assign o_cmd.line_end = i_item.line_end;
    assign o_push         = i_accept && ((seg0.kind != SEG_NONE) || (seg1.kind != SEG_NONE));

    // Run state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_byte  <= 8'd0;
            r_run_count <= 4'd0;
            r_run_split <= 1'b0;
        end else if (i_accept) begin
            r_run_byte  <= n_run_byte;
            r_run_count <= n_run_count;
            r_run_split <= n_run_split;
        end
    end

endmodule

/* rtl/trle_queue.sv */
// ---------------------------------------------------------------------------
// trle_queue
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trle_queue import trle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

endmodule

/* rtl/trle_back.sv */
// ---------------------------------------------------------------------------
// trle_back
// Walks each queued command and sends its bytes, one beat per cycle while popped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trle_back import trle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_cmd,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_result
);

    logic       r_valid;
    t_out       r_out;
    logic [1:0] r_pos;

    logic [2:0] len0;
    logic [2:0] len1;
    logic [2:0] total;
    logic [2:0] pos_ext;
    logic [2:0] idx1;
    logic [7:0] sel_byte;
    logic       is_last;
    logic       load;

    // Bytes produced by one segment
    function automatic logic [2:0] seg_len(input t_seg s);
        case (s.kind)
            SEG_RAW:   return s.num[2:0];
            SEG_CODED: return 3'd3;
            default:   return 3'd0;
        endcase
    endfunction

    // Byte at a position inside one segment
    function automatic logic [7:0] seg_byte(input t_seg s, input logic [1:0] idx);
        if (s.kind == SEG_CODED) begin
            case (idx)
                2'd0:    return DIGIT_BASE + {4'd0, s.num};
                2'd1:    return AT_SIGN;
                default: return s.sym;
            endcase
        end
        return s.sym;
    endfunction

    // Select the current byte of the head command
    always_comb begin
        len0    = seg_len(i_cmd.seg0);
        len1    = seg_len(i_cmd.seg1);
        total   = len0 + len1;
        pos_ext = {1'b0, r_pos};
        idx1    = pos_ext - len0;
        if (pos_ext < len0) begin
            sel_byte = seg_byte(i_cmd.seg0, r_pos);
        end else begin
            sel_byte = seg_byte(i_cmd.seg1, idx1[1:0]);
        end
        is_last = ((pos_ext + 3'd1) == total);
        load    = !i_q_empty && (!r_valid || i_pop);
    end

    assign o_q_pop  = load && is_last;
    assign o_empty  = !r_valid;
    assign o_result = r_out;

    // Output register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= is_last ? 2'd0 : (r_pos + 2'd1);
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.code_byte    <= sel_byte;
            r_out.last_of_item <= is_last;
            r_out.line_done    <= is_last && i_cmd.line_end;
        end
    end

endmodule
